FILE: src/bffa_pkg.sv
// shared types and constants for the first-fit block allocator
package bffa_pkg;

    localparam int NUM_BLOCKS = 64;
    localparam int LEN_W      = 7;
    localparam int START_W    = 6;
    localparam int MAP_W      = 64;
    localparam int CNT_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // data handed from one cell to the next
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   run;
    } t_link;

    // request length and mark command broadcast to every cell
    typedef struct packed {
        logic               en;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_mark;

endpackage

FILE: src/bffa_if.sv
// handshake channels for allocation requests and results
interface bffa_req_if;
    import bffa_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] request_blocks;
    modport source (output valid, output request_blocks, input ready);
    modport sink (input valid, input request_blocks, output ready);
endinterface

interface bffa_rsp_if;
    import bffa_pkg::*;
    logic               valid;
    logic               ready;
    logic               failed;
    logic [START_W-1:0] start_block;
    logic [MAP_W-1:0]   occupancy_map;
    modport source (output valid, output failed, output start_block,
                    output occupancy_map, input ready);
    modport sink (input valid, input failed, input start_block,
                  input occupancy_map, output ready);
endinterface

FILE: src/bffa_cell.sv
// one block of the bitmap: its used bit and one stage of the free-run search
module bffa_cell
    import bffa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [START_W-1:0] i_index,
    input  t_link              i_link,
    input  t_mark              i_mark,
    output t_link              o_link,
    output logic               o_used
);

    logic               r_used;
    t_link              r_link;
    logic [LEN_W-1:0]   w_run;
    logic               w_hit;
    logic [LEN_W-1:0]   w_first;
    logic [START_W-1:0] w_diff;
    logic               w_in_run;

    // length of the free run that ends at this block
    assign w_run   = r_used ? '0 : i_link.run + LEN_W'(1);
    assign w_hit   = (w_run == i_mark.len);
    assign w_first = {1'b0, i_index} + LEN_W'(1) - i_mark.len;

    assign w_diff   = i_index - i_mark.start;
    assign w_in_run = (i_index >= i_mark.start) && ({1'b0, w_diff} < i_mark.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_link <= '0;
        end else begin
            if (i_mark.en && w_in_run) begin
                r_used <= 1'b1;
            end
            r_link.run   <= w_run;
            r_link.found <= i_link.found || w_hit;
            r_link.start <= i_link.found ? i_link.start : w_first[START_W-1:0];
        end
    end

    assign o_link = r_link;
    assign o_used = r_used;

endmodule

FILE: src/bitmap_first_fit_allocator_unit.sv
// First-fit contiguous block allocator over a 64-block occupancy bitmap. Each block is one cell
// in a chain; a request's free-run count travels one cell per clock, so a nonzero request is
// searched in ST_SCAN while the count crosses all NUM_BLOCKS cells, its run is marked in ST_DONE,
// and its result is offered in ST_OUT. One request is handled at a time: the next request is
// accepted only after the result has been taken and the unit is back in ST_IDLE. A zero-length
// request skips the search and goes from ST_IDLE straight to ST_DONE and then ST_OUT. A failed
// request leaves the bitmap unchanged; blocks are never freed.
module bitmap_first_fit_allocator_unit
    import bffa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bffa_req_if.sink   i_req,
    bffa_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_OUT
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_len;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_failed;
    logic [START_W-1:0] r_start;

    t_link                 w_in   [NUM_BLOCKS];
    t_link                 w_link [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] w_used;
    t_mark                 w_mark;
    logic                  w_found;
    logic [START_W-1:0]    w_start;
    logic                  w_accept;

    assign w_accept = i_req.valid && i_req.ready;

    // zero length always fits at block zero
    assign w_found = (r_len == '0) || w_link[NUM_BLOCKS-1].found;
    assign w_start = (r_len == '0) ? '0 : w_link[NUM_BLOCKS-1].start;

    assign w_mark.en    = (r_state == ST_DONE) && w_found && (r_len != '0);
    assign w_mark.start = w_start;
    assign w_mark.len   = r_len;

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_in[g] = '0;
        end else begin : g_body
            assign w_in[g] = w_link[g-1];
        end
        bffa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (START_W'(g)),
            .i_link  (w_in[g]),
            .i_mark  (w_mark),
            .o_link  (w_link[g]),
            .o_used  (w_used[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_cnt    <= '0;
            r_failed <= 1'b0;
            r_start  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_len   <= i_req.request_blocks;
                        r_cnt   <= '0;
                        r_state <= (i_req.request_blocks == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // the last cell holds the settled result by ST_DONE
                    if (r_cnt == CNT_W'(NUM_BLOCKS - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_DONE: begin
                    r_failed <= !w_found;
                    r_start  <= w_found ? w_start : '0;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = (r_state == ST_OUT);
    assign o_rsp.failed        = r_failed;
    assign o_rsp.start_block   = r_start;
    assign o_rsp.occupancy_map = MAP_W'(w_used);

    a_fail_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.failed |-> o_rsp.start_block == '0)
        else $error("failed result with nonzero start block");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while a result is pending");

    a_map_holds_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |=> $stable(w_used))
        else $error("bitmap changed during search");

    a_fail_keeps_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && !w_found |=> $stable(w_used))
        else $error("failed request changed the bitmap");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.ready |=> i_req.ready)
        else $error("not ready after result was taken");

endmodule

FILE: dv/tb.sv
// testbench for the first-fit block allocator: directed table plus random requests
`timescale 1ns / 100ps

module tb;
    import bffa_pkg::*;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int TAIL_CYCLES     = 100;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_PHASES      = 4;

    typedef struct packed {
        logic               failed;
        logic [START_W-1:0] start;
        logic [MAP_W-1:0]   map;
    } alloc_res_t;

    typedef struct {
        logic [LEN_W-1:0] len;
        bit               typed;
        alloc_res_t       res;
    } dir_row_t;

    // typed rows hold results that follow directly from an empty disk
    dir_row_t dir_rows [10] = '{
        '{7'd0,   1'b1, '{1'b0, 6'd0, 64'h0}},
        '{7'd127, 1'b1, '{1'b1, 6'd0, 64'h0}},
        '{7'd65,  1'b1, '{1'b1, 6'd0, 64'h0}},
        '{7'd1,   1'b1, '{1'b0, 6'd0, 64'h1}},
        '{7'd64,  1'b1, '{1'b1, 6'd0, 64'h1}},
        '{7'd0,   1'b1, '{1'b0, 6'd0, 64'h1}},
        '{7'd2,   1'b0, '0},
        '{7'd62,  1'b0, '0},
        '{7'd3,   1'b0, '0},
        '{7'd59,  1'b0, '0}
    };

    int snd_idle_pct [NUM_PHASES] = '{0, 48, 0, 32};
    int rcv_stall_pct [NUM_PHASES] = '{0, 0, 48, 32};

    logic i_clk;
    logic i_rst_n;

    bffa_req_if req_if ();
    bffa_rsp_if rsp_if ();

    bitmap_first_fit_allocator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [MAP_W-1:0] alloc_map = '0;
    logic [MAP_W-1:0] map_snap  = '0;
    alloc_res_t       alloc_q [$];
    int               err_cnt   = 0;
    int               snd_pct   = 0;
    int               rcv_pct   = 0;
    int               hold_token = 0;
    int               hold_seen  = 0;
    int               hold_left  = 0;
    int               idle_cnt   = 0;
    bit               row_typed  = 1'b0;
    alloc_res_t       row_res    = '0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // first-fit search over the occupancy map, updates the map on success
    function automatic alloc_res_t first_fit_alloc(input logic [LEN_W-1:0] len);
        alloc_res_t       r;
        logic [MAP_W-1:0] run;
        int               pos;
        r.failed = 1'b1;
        r.start  = '0;
        if (len == 0) begin
            r.failed = 1'b0;
        end else if (len <= NUM_BLOCKS) begin
            run = (len >= MAP_W) ? '1 : (MAP_W'(1) << len) - MAP_W'(1);
            for (pos = 0; pos + len <= NUM_BLOCKS && r.failed; pos++) begin
                if ((alloc_map & (run << pos)) == '0) begin
                    alloc_map = alloc_map | (run << pos);
                    r.start   = pos[START_W-1:0];
                    r.failed  = 1'b0;
                end
            end
        end
        r.map = alloc_map;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (err_cnt < MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", what, want, got);
        err_cnt++;
    endtask

    // mostly short runs while space is left so every start position gets used
    function automatic logic [LEN_W-1:0] pick_len();
        int free_cnt;
        int pick;
        free_cnt = NUM_BLOCKS - $countones(map_snap);
        pick     = $urandom_range(99);
        if (pick < 15)
            return '0;
        else if (pick < 70 && free_cnt > 0)
            return LEN_W'($urandom_range(3, 1));
        else if (pick < 85)
            return LEN_W'($urandom_range(free_cnt + 2, 1));
        else
            return LEN_W'($urandom_range(127, 0));
    endfunction

    task automatic offer_request(input logic [LEN_W-1:0] len, input bit typed,
                                 input alloc_res_t res);
        while ($urandom_range(99) < snd_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.request_blocks <= len;
        row_typed             <= typed;
        row_res               <= res;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // the last accepted item is queued by the scoreboard at the same edge, so look later
    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (alloc_q.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // receiver: random stalls plus a long hold-off each time hold_token is bumped
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready  <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            rsp_if.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_if.ready  <= 1'b0;
        end else begin
            rsp_if.ready  <= ($urandom_range(99) >= rcv_pct);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        alloc_res_t want;
        alloc_res_t pred;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (alloc_q.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("unexpected result: failed %b start %0d map %h",
                                 rsp_if.failed, rsp_if.start_block, rsp_if.occupancy_map);
                    err_cnt++;
                end else begin
                    want = alloc_q.pop_front();
                    if (rsp_if.failed !== want.failed)
                        note_mismatch("failed", 64'(want.failed), 64'(rsp_if.failed));
                    if (rsp_if.start_block !== want.start)
                        note_mismatch("start_block", 64'(want.start),
                                      64'(rsp_if.start_block));
                    if (rsp_if.occupancy_map !== want.map)
                        note_mismatch("occupancy_map", want.map, rsp_if.occupancy_map);
                end
            end
            if (req_if.valid && req_if.ready) begin
                pred = first_fit_alloc(req_if.request_blocks);
                alloc_q.push_back(row_typed ? row_res : pred);
            end
            map_snap <= alloc_map;
        end
    end

    // ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt == IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.request_blocks = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i].len, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            snd_pct = snd_idle_pct[p];
            rcv_pct = rcv_stall_pct[p];
            // input keeps offering while the output is held off, so the unit backs up
            if (p == 0)
                hold_token <= hold_token + 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_request(pick_len(), 1'b0, '0);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && alloc_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
